/* rtl/tlni_pkg.sv */
// shared types, widths and codes for the torus lattice neighbor index block
package tlni_pkg;

    // lattice limits
    localparam int MAX_DIM     = 4;
    localparam int VERTEX_BITS = 20;

    // field widths
    localparam int VERTEX_W   = 21;
    localparam int SLOT_W     = 20;
    localparam int OFFSET_W   = 24;
    localparam int STATUS_W   = 2;
    localparam int SIDE_W     = 11;
    localparam int DIMS_W     = 3;
    localparam int DEG_W      = DIMS_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // power-of-side words, saturated just above the vertex limit
    localparam int PW_W   = VERTEX_BITS + 1;
    localparam int DIM_IW = $clog2(MAX_DIM + 1);
    localparam int NB_W   = ((PW_W > VERTEX_W) ? PW_W : VERTEX_W) + 1;

    localparam logic [PW_W-1:0] PW_LIMIT = {1'b1, {VERTEX_BITS{1'b0}}};
    localparam logic [PW_W-1:0] PW_SAT   = PW_LIMIT + PW_W'(1);

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_VERTEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST = 2'd2;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [SLOT_W-1:0]   slot;
    } t_in;

    typedef struct packed {
        logic [VERTEX_W-1:0] neighbor;
        logic [OFFSET_W-1:0] entry_offset;
        logic [STATUS_W-1:0] status;
    } t_out;

    // item state carried through the modulo pipeline
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                lattice;
        logic                dir_back;
        logic [VERTEX_W-1:0] vertex;
        logic [VERTEX_W-1:0] nb;
        logic [OFFSET_W-1:0] offset;
        logic [PW_W-1:0]     stride;
        logic [PW_W-1:0]     modulus;
        logic [VERTEX_W-1:0] rem;
    } t_work;

endpackage

/* rtl/tlni_modp.sv */
// restoring remainder pipeline: vertex mod (stride * side), one quotient bit a stage
module tlni_modp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  logic          i_valid,
    input  tlni_pkg::t_work i_work,
    output logic          o_valid,
    output tlni_pkg::t_work o_work
);
    import tlni_pkg::*;

    localparam int NSTEP = VERTEX_W;
    localparam int W     = PW_W + VERTEX_W;

    t_work r_w [0:NSTEP-1];
    logic  r_v [0:NSTEP-1];

    // one compare and subtract of the shifted modulus
    function automatic t_work f_step(t_work w, int unsigned sh);
        t_work        res;
        logic [W-1:0] dsor;
        logic [W-1:0] rm;
        res  = w;
        dsor = W'(w.modulus) << sh;
        rm   = W'(w.rem);
        if (rm >= dsor) begin
            res.rem = VERTEX_W'(rm - dsor);
        end
        return res;
    endfunction

    // stage registers, valid bits travel with the data
    for (genvar k = 0; k < NSTEP; k++) begin : g_stage
        t_work w_src;
        logic  w_srcv;
        if (k == 0) begin : g_first
            assign w_src  = i_work;
            assign w_srcv = i_valid;
        end else begin : g_next
            assign w_src  = r_w[k-1];
            assign w_srcv = r_v[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_adv) begin
                r_v[k] <= w_srcv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_w[k] <= f_step(w_src, NSTEP - 1 - k);
            end
        end
    end

    assign o_valid = r_v[NSTEP-1];
    assign o_work  = r_w[NSTEP-1];

    // remainder is fully reduced at the end
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_work.lattice) |-> (NB_W'(o_work.rem) < NB_W'(o_work.modulus)))
        else $error("remainder not reduced below modulus");

    // a held pipeline keeps its last valid bit
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(o_valid))
        else $error("last stage valid changed while held");

endmodule

/* rtl/torus_lattice_neighbor_index.sv */
// top level: neighbor and adjacency offset of a vertex slot on a periodic lattice
// pipeline: MAX_DIM + 1 settling stages, one classify stage, 21 remainder stages,
// and one output stage
// throughput: one item per cycle; a stalled output holds the whole pipeline
// reset: synchronous active low, clears valid bits and loads side 2, two dimensions, no ghost
module torus_lattice_neighbor_index (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  tlni_pkg::t_in                       i_item,
    output logic                                o_valid,
    input  logic                                i_stall,
    output tlni_pkg::t_out                      o_result,
    input  logic                                i_cfg_we,
    input  logic [tlni_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tlni_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tlni_pkg::*;

    localparam int DLY = MAX_DIM + 1;
    localparam int PRD_W = PW_W + SIDE_W;
    localparam int OFF_PW = VERTEX_W + DEG_W;

    logic [SIDE_W-1:0] r_side;
    logic [DIMS_W-1:0] r_dims;
    logic              r_ghost;

    logic [PW_W-1:0]   r_pw [0:MAX_DIM];
    logic [PW_W-1:0]   r_nv;
    logic              r_too_large;
    logic [DIM_IW-1:0] w_dsel;

    logic              r_dv [0:DLY-1];
    t_in               r_dd [0:DLY-1];

    t_work             n_w0;
    t_work             r_w0;
    logic              r_v0;

    logic              w_mv;
    t_work             w_mo;

    t_out              n_out;
    t_out              r_out;
    logic              r_ov;
    logic              w_adv;

    // pipeline moves unless a finished item is held at the output
    assign w_adv   = !(r_ov && i_stall);
    assign o_stall = !w_adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= SIDE_W'(2);
            r_dims  <= DIMS_W'(2);
            r_ghost <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIDE:  r_side  <= i_cfg_data[SIDE_W-1:0];
                CFG_DIMS:  r_dims  <= i_cfg_data[DIMS_W-1:0];
                CFG_GHOST: r_ghost <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // powers of the side, one saturating multiply per register above the first power
    always_ff @(posedge i_clk) begin
        r_pw[0] <= PW_W'(1);
        r_pw[1] <= PW_W'(r_side);
    end

    for (genvar k = 2; k <= MAX_DIM; k++) begin : g_pow
        logic [PRD_W-1:0] w_prod;
        assign w_prod = PRD_W'(r_pw[k-1]) * PRD_W'(r_side);
        always_ff @(posedge i_clk) begin
            r_pw[k] <= (w_prod > PRD_W'(PW_LIMIT)) ? PW_SAT : w_prod[PW_W-1:0];
        end
    end

    // vertex count and size check
    assign w_dsel = (int'(r_dims) > MAX_DIM) ? '0 : DIM_IW'(r_dims);

    always_ff @(posedge i_clk) begin
        r_nv        <= r_pw[w_dsel];
        r_too_large <= (int'(r_dims) > MAX_DIM) || (r_pw[w_dsel] > PW_LIMIT);
    end

    // settling delay line
    for (genvar k = 0; k < DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (w_adv) begin
                r_dv[k] <= (k == 0) ? (i_valid && !o_stall) : r_dv[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dd[k] <= (k == 0) ? i_item : r_dd[(k == 0) ? 0 : k-1];
            end
        end
    end

    // classify the item and set up the remainder
    always_comb begin
        t_in                 w_in;
        logic [DEG_W-1:0]    w_deg;
        logic [SLOT_W-2:0]   w_j;
        logic [DIM_IW-1:0]   w_ji;
        logic [DIM_IW-1:0]   w_jn;
        logic [OFF_PW-1:0]   w_off;
        logic                w_gsrc;
        w_in   = r_dd[DLY-1];
        w_deg  = {r_dims, r_ghost};
        w_j    = w_in.slot[SLOT_W-1:1];
        w_ji   = (w_j < MAX_DIM) ? DIM_IW'(w_j) : '0;
        w_jn   = w_ji + DIM_IW'(1);
        w_off  = OFF_PW'(w_in.vertex) * OFF_PW'(w_deg) + OFF_PW'(w_in.slot);
        w_gsrc = r_ghost && (NB_W'(w_in.vertex) == NB_W'(r_nv));

        n_w0.status   = ST_OK;
        n_w0.lattice  = 1'b0;
        n_w0.dir_back = w_in.slot[0];
        n_w0.vertex   = w_in.vertex;
        n_w0.nb       = '0;
        n_w0.offset   = w_off[OFFSET_W-1:0];
        n_w0.stride   = r_pw[w_ji];
        n_w0.modulus  = r_pw[w_jn];
        n_w0.rem      = w_in.vertex;

        priority if (r_too_large) begin
            n_w0.status = ST_TOO_LARGE;
            n_w0.offset = '0;
        end else if (w_gsrc) begin
            if (NB_W'(w_in.slot) >= NB_W'(r_nv)) begin
                n_w0.status = ST_BAD_SLOT;
                n_w0.offset = '0;
            end else begin
                n_w0.nb = VERTEX_W'(w_in.slot);
            end
        end else if (NB_W'(w_in.vertex) >= NB_W'(r_nv)) begin
            n_w0.status = ST_BAD_VERTEX;
            n_w0.offset = '0;
        end else if (w_in.slot >= SLOT_W'(w_deg)) begin
            n_w0.status = ST_BAD_SLOT;
            n_w0.offset = '0;
        end else if (w_in.slot == SLOT_W'({r_dims, 1'b0})) begin
            n_w0.nb = VERTEX_W'(r_nv);
        end else begin
            n_w0.lattice = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= r_dv[DLY-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w0 <= n_w0;
        end
    end

    tlni_modp u_modp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v0),
        .i_work  (r_w0),
        .o_valid (w_mv),
        .o_work  (w_mo)
    );

    // wrap step from the coordinate remainder
    always_comb begin
        logic [NB_W-1:0] w_v;
        logic [NB_W-1:0] w_s;
        logic [NB_W-1:0] w_m;
        logic [NB_W-1:0] w_r;
        logic [NB_W-1:0] w_nb;
        w_v  = NB_W'(w_mo.vertex);
        w_s  = NB_W'(w_mo.stride);
        w_m  = NB_W'(w_mo.modulus);
        w_r  = NB_W'(w_mo.rem);
        w_nb = NB_W'(w_mo.nb);
        if (w_mo.lattice) begin
            if (!w_mo.dir_back) begin
                w_nb = ((w_r + w_s) >= w_m) ? (w_v + w_s - w_m) : (w_v + w_s);
            end else begin
                w_nb = (w_r < w_s) ? (w_v + w_m - w_s) : (w_v - w_s);
            end
        end
        n_out.neighbor     = VERTEX_W'(w_nb);
        n_out.entry_offset = w_mo.offset;
        n_out.status       = w_mo.status;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= w_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

    // error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out.status != ST_OK)) |->
            ((r_out.neighbor == '0) && (r_out.entry_offset == '0)))
        else $error("error result with nonzero payload");

    // stall toward the source only while a result is held
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_ov)
        else $error("input stalled with empty output");

    // a good neighbor never exceeds the ghost index
    a_nb_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out.status == ST_OK)) |-> (NB_W'(r_out.neighbor) <= NB_W'(r_nv)))
        else $error("neighbor beyond vertex count");

endmodule

/* tb/torus_lattice_neighbor_index_tb.sv */
// testbench for the torus lattice neighbor index block: directed rows, random items, predictor
`timescale 1ns / 1ps

module torus_lattice_neighbor_index_tb;
    import tlni_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 1650;

    // one directed row: configuration, item, and a typed-in result where obvious
    typedef struct {
        int unsigned side;
        int unsigned dims;
        int unsigned ghost;
        int unsigned vertex;
        int unsigned slot;
        bit          known;
        t_out        result;
    } t_row;

    typedef struct {
        int unsigned side;
        int unsigned dims;
        int unsigned ghost;
    } t_setting;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in        i_item;
    logic       o_valid;
    logic       i_stall;
    t_out       o_result;
    logic       i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // lattice configuration as the block should hold it
    int unsigned lat_side;
    int unsigned lat_dims;
    int unsigned lat_ghost;

    t_out        pending_results[$];
    int unsigned fail_count = 0;
    int unsigned row_fail_count = 0;
    int unsigned cycle_count = 0;
    bit          calm_sender;
    bit          calm_receiver;

    torus_lattice_neighbor_index DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock, 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // vertex count of the lattice, flagging one over the vertex range
    function automatic longint unsigned lattice_count(output bit too_big);
        longint unsigned nv;
        too_big = 1'b0;
        nv = 1;
        if (lat_dims > MAX_DIM) begin
            too_big = 1'b1;
        end else begin
            for (int d = 0; d < lat_dims; d++) begin
                nv = nv * lat_side;
                if (nv > (64'd1 << VERTEX_BITS)) begin
                    too_big = 1'b1;
                    break;
                end
            end
        end
        return nv;
    endfunction

    // neighbor, list offset and status of one lookup
    function automatic t_out lookup_neighbor(t_in it);
        t_out r;
        bit too_big;
        longint unsigned nv, deg, v, s, j, stride, coord, nxt;
        r = '0;
        v = it.vertex;
        s = it.slot;
        nv = lattice_count(too_big);
        deg = 2 * lat_dims + lat_ghost;
        if (too_big) begin
            r.status = ST_TOO_LARGE;
        end else if (lat_ghost != 0 && v == nv) begin
            if (s >= nv) begin
                r.status = ST_BAD_SLOT;
            end else begin
                r.neighbor = VERTEX_W'(s);
                r.entry_offset = OFFSET_W'(deg * v + s);
                r.status = ST_OK;
            end
        end else if (v >= nv) begin
            r.status = ST_BAD_VERTEX;
        end else if (s >= deg) begin
            r.status = ST_BAD_SLOT;
        end else if (s == 2 * lat_dims) begin
            r.neighbor = VERTEX_W'(nv);
            r.entry_offset = OFFSET_W'(deg * v + s);
        end else begin
            j = s >> 1;
            stride = 1;
            for (longint unsigned d = 0; d < j; d++) stride = stride * lat_side;
            coord = (v / stride) % lat_side;
            if (s[0] == 1'b0) nxt = (coord + 1) % lat_side;
            else nxt = (coord + lat_side - 1) % lat_side;
            r.neighbor = VERTEX_W'(v - coord * stride + nxt * stride);
            r.entry_offset = OFFSET_W'(deg * v + s);
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned idle_len(bit calm);
        int unsigned p;
        if (calm) return 0;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(20, 8);
    endfunction

    // random item, mostly well formed for the current lattice
    function automatic t_in random_item();
        t_in it;
        bit too_big;
        longint unsigned nv, deg;
        int unsigned p;
        nv = lattice_count(too_big);
        deg = 2 * lat_dims + lat_ghost;
        p = $urandom_range(99);
        it.vertex = VERTEX_W'($urandom);
        it.slot = SLOT_W'($urandom);
        if (too_big || p >= 85) begin
            // noise over the whole field range
        end else if (p < 65 && nv > 0 && deg > 0) begin
            it.vertex = VERTEX_W'($urandom_range(int'(nv - 1)));
            it.slot = SLOT_W'($urandom_range(int'(deg - 1)));
        end else if (p < 75 && lat_ghost != 0) begin
            it.vertex = VERTEX_W'(nv);
            if (nv > 0) it.slot = SLOT_W'($urandom_range(int'(nv - 1)));
            if ($urandom_range(3) == 0) it.slot = SLOT_W'(nv + $urandom_range(2));
        end else begin
            // just past the legal edges
            it.vertex = VERTEX_W'(nv + $urandom_range(2) - 1);
            it.slot = SLOT_W'(deg + $urandom_range(1));
        end
        return it;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for the pipeline to empty, then load a new lattice
    task automatic load_lattice(int unsigned side, int unsigned dims, int unsigned ghost);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(CFG_SIDE, side);
        write_reg(CFG_DIMS, dims);
        write_reg(CFG_GHOST, ghost);
        lat_side = side;
        lat_dims = dims;
        lat_ghost = ghost;
    endtask

    // present one item until taken; expectation queued just before the taking edge
    task automatic send_item(t_in it, bit known, t_out fixed);
        int unsigned gap;
        t_out want;
        gap = idle_len(calm_sender);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        #1;
        while (o_stall) begin
            @(negedge i_clk);
            #1;
        end
        want = lookup_neighbor(it);
        if (known && want != fixed) begin
            $error("directed row disagrees with predictor: row %h predicted %h", fixed, want);
            row_fail_count++;
        end
        pending_results.push_back(known ? fixed : want);
        @(negedge i_clk);
    endtask

    // receiver: random stall, result captured before the edge and checked on it
    initial begin
        logic seen_valid;
        t_out seen;
        t_out want;
        i_stall = 1'b1;
        forever begin
            @(negedge i_clk);
            i_stall <= (idle_len(calm_receiver) != 0);
            #1;
            seen_valid = o_valid;
            seen = o_result;
            @(posedge i_clk);
            if (i_rst_n && seen_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with nothing expected: %h", seen);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (seen.neighbor !== want.neighbor) begin
                        $error("neighbor: expected %0d, got %0d", want.neighbor, seen.neighbor);
                        fail_count++;
                    end
                    if (seen.entry_offset !== want.entry_offset) begin
                        $error("entry_offset: expected %0d, got %0d",
                               want.entry_offset, seen.entry_offset);
                        fail_count++;
                    end
                    if (seen.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, seen.status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_row rows[$];
        t_setting settings[$];
        t_out err_vertex, err_slot, err_large;
        t_in it;
        int unsigned per_phase;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        calm_sender = 1'b0;
        calm_receiver = 1'b0;
        lat_side = 2;
        lat_dims = 2;
        lat_ghost = 0;

        err_vertex = '{neighbor: '0, entry_offset: '0, status: ST_BAD_VERTEX};
        err_slot = '{neighbor: '0, entry_offset: '0, status: ST_BAD_SLOT};
        err_large = '{neighbor: '0, entry_offset: '0, status: ST_TOO_LARGE};

        // reset lattice: side 2, two dimensions, no ghost
        rows.push_back('{2, 2, 0, 0, 0, 1'b0, '0});
        rows.push_back('{2, 2, 0, 0, 1, 1'b0, '0});
        rows.push_back('{2, 2, 0, 3, 2, 1'b0, '0});
        rows.push_back('{2, 2, 0, 3, 3, 1'b0, '0});
        rows.push_back('{2, 2, 0, 4, 0, 1'b1, err_vertex});
        rows.push_back('{2, 2, 0, 21'h1FFFFF, 0, 1'b1, err_vertex});
        rows.push_back('{2, 2, 0, 1, 4, 1'b1, err_slot});
        rows.push_back('{2, 2, 0, 1, 20'hFFFFF, 1'b1, err_slot});
        // side one: steps return the vertex itself, plus ghost slot and ghost vertex
        rows.push_back('{1, 3, 1, 0, 5, 1'b0, '0});
        rows.push_back('{1, 3, 1, 0, 6, 1'b0, '0});
        rows.push_back('{1, 3, 1, 1, 0, 1'b0, '0});
        rows.push_back('{1, 3, 1, 1, 1, 1'b1, err_slot});
        // largest lattice that fits, wrap on both ends of the top dimension
        rows.push_back('{1024, 2, 1, 0, 3, 1'b0, '0});
        rows.push_back('{1024, 2, 1, 1048575, 2, 1'b0, '0});
        rows.push_back('{1024, 2, 1, 1048576, 1048575, 1'b0, '0});
        rows.push_back('{1024, 2, 1, 1048577, 0, 1'b1, err_vertex});
        // lattice too large by size and by dimension count
        rows.push_back('{1024, 3, 0, 0, 0, 1'b1, err_large});
        rows.push_back('{3, 7, 1, 0, 0, 1'b1, err_large});
        // zero side: no lattice vertex, ghost takes no slot
        rows.push_back('{0, 1, 1, 0, 0, 1'b1, err_slot});
        rows.push_back('{0, 1, 1, 1, 0, 1'b1, err_vertex});
        // zero dimensions: single vertex, only the ghost slot
        rows.push_back('{5, 0, 1, 0, 0, 1'b0, '0});
        rows.push_back('{5, 0, 1, 1, 0, 1'b0, '0});
        rows.push_back('{5, 0, 0, 0, 0, 1'b1, err_slot});

        settings = '{'{2, 2, 0}, '{1, 4, 1}, '{1024, 1, 1}, '{1024, 2, 0},
                     '{1024, 2, 1}, '{32, 4, 1}, '{3, 4, 0}, '{0, 1, 1},
                     '{7, 0, 1}, '{2047, 1, 0}, '{5, 3, 1}, '{2, 7, 0},
                     '{1, 0, 0}, '{17, 2, 1}, '{33, 4, 1}};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed rows
        foreach (rows[k]) begin
            if (rows[k].side != lat_side || rows[k].dims != lat_dims
                    || rows[k].ghost != lat_ghost) begin
                i_valid <= 1'b0;
                load_lattice(rows[k].side, rows[k].dims, rows[k].ghost);
            end
            it.vertex = VERTEX_W'(rows[k].vertex);
            it.slot = SLOT_W'(rows[k].slot);
            send_item(it, rows[k].known, rows[k].result);
        end

        // random items over fixed and random lattices
        per_phase = RANDOM_ITEMS / (settings.size() + 5);
        for (int p = 0; p < settings.size() + 5; p++) begin
            i_valid <= 1'b0;
            if (p < settings.size())
                load_lattice(settings[p].side, settings[p].dims, settings[p].ghost);
            else
                load_lattice($urandom_range(40, 1), $urandom_range(4, 1), $urandom_range(1));
            for (int n = 0; n < per_phase; n++) begin
                if (n % 40 == 0) begin
                    calm_sender = ($urandom_range(3) == 0);
                    calm_receiver = ($urandom_range(3) == 0);
                end
                send_item(random_item(), 1'b0, '0);
            end
        end

        // drain
        i_valid <= 1'b0;
        calm_receiver = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && row_fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tlni_pkg.sv
rtl/tlni_modp.sv
rtl/torus_lattice_neighbor_index.sv
tb/torus_lattice_neighbor_index_tb.sv
